FILE: src/tof_median_range_gate_assert.svh
// Assertion macros for the range gate and median filter.
`ifndef TOF_MEDIAN_RANGE_GATE_ASSERT_SVH
`define TOF_MEDIAN_RANGE_GATE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TMRG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tmrg_pkg.sv
// Shared constants and types for the range gate and median filter.
`default_nettype none

package tmrg_pkg;

  localparam int DIST_W = 13;
  localparam int RAW_W  = 16;
  localparam int SEL_W  = 1;
  localparam int MASK_W = 2;
  localparam int CFG_W  = 2;

  localparam logic [RAW_W-1:0]  REJECT_LIMIT = 16'd8190;
  localparam logic [MASK_W-1:0] READY_MASK_RST = 2'd3;
  localparam logic [DIST_W-1:0] MIN_DIST_RST = 13'd0;
  localparam logic [DIST_W-1:0] MAX_DIST_RST = 13'd8189;

  localparam int WINDOW_DEF  = 5;
  localparam int SENSORS_DEF = 2;

  typedef enum logic [CFG_W-1:0] {
    REG_READY_MASK = 2'd0,
    REG_MIN_DIST   = 2'd1,
    REG_MAX_DIST   = 2'd2
  } cfg_reg_t;

  // Control broadcast from the sequencer to every window cell.
  typedef struct packed {
    logic             load;
    logic             step;
    logic [SEL_W-1:0] sel;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/tof_median_range_gate.sv
// Top level: range gate and running median filter over a ring of window cells.
//
// Requests arrive on req_valid/req_stall with sensor_sel, raw_mm and timed_out.
// A request is taken when req_valid is high and req_stall is low; req_stall is
// high while a request is in work. Each request gives exactly one result on
// res_valid/res_stall (sensor_out, distance_mm), held until res_stall is low.
// Configuration: cfg_we with cfg_index (0 ready mask, 1 minimum, 2 maximum)
// and cfg_data; other indexes are dropped.
// A kept reading runs the rank pass in S_RUN, then its result is registered
// in S_DONE; a rejected reading goes from acceptance straight to S_DONE.
// The next request is taken in the cycle after the result is registered.
// In the rank pass each sample travels once around the ring
// of WINDOW cells, one hop per cycle.
// A result waiting under res_stall does not block acceptance of the next
// request, but that request's result waits until the output register frees,
// and req_stall stays high meanwhile.
// Reset clears the write positions, fill flags and registers to their reset
// values; window contents are not cleared, and only written slots are read.
`default_nettype none

module tof_median_range_gate #(
  parameter int WINDOW  = tmrg_pkg::WINDOW_DEF,
  parameter int SENSORS = tmrg_pkg::SENSORS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          req_valid,
  output logic                         req_stall,
  input  wire  [tmrg_pkg::SEL_W-1:0]   sensor_sel,
  input  wire  [tmrg_pkg::RAW_W-1:0]   raw_mm,
  input  wire                          timed_out,
  output logic                         res_valid,
  input  wire                          res_stall,
  output logic [tmrg_pkg::SEL_W-1:0]   sensor_out,
  output logic [tmrg_pkg::DIST_W-1:0]  distance_mm,
  input  wire                          cfg_we,
  input  wire  [tmrg_pkg::CFG_W-1:0]   cfg_index,
  input  wire  [tmrg_pkg::DIST_W-1:0]  cfg_data
);
  import tmrg_pkg::*;

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int ROWS  = (SENSORS > 2) ? 2 : SENSORS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  logic [MASK_W-1:0] ready_mask;
  logic [DIST_W-1:0] min_distance;
  logic [DIST_W-1:0] max_distance;

  logic [IDX_W-1:0] wpos  [ROWS];
  logic             wfull [ROWS];

  logic [CNT_W-1:0] step_cnt;
  logic [CNT_W-1:0] count;
  logic [SEL_W-1:0] cur_sel;
  logic             cur_good;

  logic             accept;
  logic             good_in;
  logic             res_load;
  logic [IDX_W-1:0] pos_cur;
  logic             full_cur;
  logic [IDX_W-1:0] pos_wr;
  logic [CNT_W-1:0] pos_inc;
  logic             wraps;
  logic [IDX_W-1:0] pos_new;
  logic             full_new;
  logic [CNT_W-1:0] ld_count;
  logic [CNT_W-1:0] mid;
  cell_ctrl_t       ctrl;

  logic [DIST_W-1:0] trv_val  [WINDOW];
  logic [IDX_W-1:0]  trv_idx  [WINDOW];
  logic              trv_live [WINDOW];
  logic [WINDOW-1:0] pick_vec;
  logic [DIST_W-1:0] pick_val [WINDOW];
  logic [DIST_W-1:0] median;
  logic [DIST_W-1:0] gated;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  assign good_in = (32'(sensor_sel) < SENSORS) && ready_mask[sensor_sel] && !timed_out &&
                   (raw_mm < REJECT_LIMIT);

  always_comb begin
    pos_cur  = '0;
    full_cur = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      if (sensor_sel == SEL_W'(r)) begin
        pos_cur  = wpos[r];
        full_cur = wfull[r];
      end
    end
  end

  assign pos_wr   = (CNT_W'(pos_cur) >= CNT_W'(WINDOW)) ? '0 : pos_cur;
  assign pos_inc  = CNT_W'(pos_wr) + CNT_W'(1);
  assign wraps    = (pos_inc == CNT_W'(WINDOW));
  assign pos_new  = wraps ? '0 : pos_inc[IDX_W-1:0];
  assign full_new = full_cur || wraps;
  assign ld_count = full_new ? CNT_W'(WINDOW) : pos_inc;

  assign ctrl.load = accept && good_in;
  assign ctrl.step = (state == S_RUN);
  assign ctrl.sel  = sensor_sel;
  assign mid       = count >> 1;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    localparam int PREV = (k == 0) ? WINDOW - 1 : k - 1;
    tmrg_cell #(
      .IDX   (k),
      .ROWS  (ROWS),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .wr_pos     (pos_wr),
      .ld_count   (ld_count),
      .new_sample (raw_mm[DIST_W-1:0]),
      .mid        (mid),
      .prev_val   (trv_val[PREV]),
      .prev_idx   (trv_idx[PREV]),
      .prev_live  (trv_live[PREV]),
      .trv_val    (trv_val[k]),
      .trv_idx    (trv_idx[k]),
      .trv_live   (trv_live[k]),
      .pick       (pick_vec[k]),
      .pick_val   (pick_val[k])
    );
  end

  // Exactly one live cell holds the middle rank; OR the cells together.
  always_comb begin
    median = '0;
    for (int k = 0; k < WINDOW; k++) begin
      median = median | pick_val[k];
    end
  end

  assign gated = (cur_good && (median >= min_distance) && (median <= max_distance)) ?
                 median : '0;

  assign res_load = (state == S_DONE) && (!res_valid || !res_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = good_in ? S_RUN : S_DONE;
        end
      end
      S_RUN: begin
        if (step_cnt == CNT_W'(WINDOW - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step_cnt     <= '0;
      res_valid    <= 1'b0;
      ready_mask   <= READY_MASK_RST;
      min_distance <= MIN_DIST_RST;
      max_distance <= MAX_DIST_RST;
      for (int r = 0; r < ROWS; r++) begin
        wpos[r]  <= '0;
        wfull[r] <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (state == S_RUN) begin
        step_cnt <= step_cnt + CNT_W'(1);
      end else begin
        step_cnt <= '0;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (ctrl.load) begin
        for (int r = 0; r < ROWS; r++) begin
          if (sensor_sel == SEL_W'(r)) begin
            wpos[r]  <= pos_new;
            wfull[r] <= full_new;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_READY_MASK: ready_mask   <= cfg_data[MASK_W-1:0];
          REG_MIN_DIST:   min_distance <= cfg_data;
          REG_MAX_DIST:   max_distance <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Hold the request fields for the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_sel  <= sensor_sel;
      cur_good <= good_in;
      count    <= ld_count;
    end
    if (res_load) begin
      sensor_out  <= cur_sel;
      distance_mm <= gated;
    end
  end

`include "tof_median_range_gate_assert.svh"

  `TMRG_ASSERT_NEXT(a_accept_starts, accept, (state != S_IDLE), "request did not start")
  `TMRG_ASSERT_IMPL(a_one_median, (state == S_DONE) && cur_good, $onehot(pick_vec), "no single median")
  `TMRG_ASSERT_IMPL(a_step_bound, (state == S_RUN), (step_cnt < CNT_W'(WINDOW)), "rank pass overran")

endmodule

`default_nettype wire

FILE: src/tmrg_cell.sv
// One window cell: holds one sample slot per sensor and ranks its sample
// against the values circulating through the ring.
`default_nettype none

module tmrg_cell #(
  parameter int IDX   = 0,
  parameter int ROWS  = 2,
  parameter int IDX_W = 3,
  parameter int CNT_W = 3
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire  tmrg_pkg::cell_ctrl_t ctrl,
  input  wire  [IDX_W-1:0]           wr_pos,
  input  wire  [CNT_W-1:0]           ld_count,
  input  wire  [tmrg_pkg::DIST_W-1:0] new_sample,
  input  wire  [CNT_W-1:0]           mid,
  input  wire  [tmrg_pkg::DIST_W-1:0] prev_val,
  input  wire  [IDX_W-1:0]           prev_idx,
  input  wire                        prev_live,
  output logic [tmrg_pkg::DIST_W-1:0] trv_val,
  output logic [IDX_W-1:0]           trv_idx,
  output logic                       trv_live,
  output logic                       pick,
  output logic [tmrg_pkg::DIST_W-1:0] pick_val
);
  import tmrg_pkg::*;

  logic [DIST_W-1:0] sample [ROWS];
  logic [DIST_W-1:0] own;
  logic              own_live;
  logic [CNT_W-1:0]  rank;
  logic [DIST_W-1:0] row_rd;
  logic              wr_here;
  logic [DIST_W-1:0] load_val;
  logic              load_live;
  logic              beats;

  always_comb begin
    row_rd = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (ctrl.sel == SEL_W'(r)) begin
        row_rd = sample[r];
      end
    end
  end

  assign wr_here   = (wr_pos == IDX_W'(IDX));
  assign load_val  = wr_here ? new_sample : row_rd;
  assign load_live = (CNT_W'(IDX) < ld_count);

  // Smaller value, or equal value from an earlier slot, sorts ahead.
  assign beats = trv_live && own_live &&
                 ((trv_val < own) || ((trv_val == own) && (trv_idx < IDX_W'(IDX))));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int r = 0; r < ROWS; r++) begin
        if (wr_here && (ctrl.sel == SEL_W'(r))) begin
          sample[r] <= new_sample;
        end
      end
      own     <= load_val;
      trv_val <= load_val;
      trv_idx <= IDX_W'(IDX);
      rank    <= '0;
    end else if (ctrl.step) begin
      trv_val <= prev_val;
      trv_idx <= prev_idx;
      if (beats) begin
        rank <= rank + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_live <= 1'b0;
      trv_live <= 1'b0;
    end else if (ctrl.load) begin
      own_live <= load_live;
      trv_live <= load_live;
    end else if (ctrl.step) begin
      trv_live <= prev_live;
    end
  end

  assign pick     = own_live && (rank == mid);
  assign pick_val = pick ? own : '0;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the sensor range gate and running median filter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tmrg_pkg::*;

  localparam int WIN = WINDOW_DEF;
  localparam int NSENS = SENSORS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int MAX_GAP = 16;
  localparam logic [CFG_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [SEL_W-1:0]  sensor;
    logic [DIST_W-1:0] distance;
  } dist_result_t;

  // Tracks per-sensor windows and the expected filtered distances.
  class median_gate_sb;
    logic [MASK_W-1:0] ready_mask;
    logic [DIST_W-1:0] min_dist;
    logic [DIST_W-1:0] max_dist;
    logic [DIST_W-1:0] samples [NSENS][WIN];
    int unsigned wr_pos [NSENS];
    bit filled [NSENS];
    dist_result_t expected_q[$];
    int errors;

    function new();
      errors = 0;
      ready_mask = READY_MASK_RST;
      min_dist = MIN_DIST_RST;
      max_dist = MAX_DIST_RST;
      foreach (wr_pos[s]) begin
        wr_pos[s] = 0;
        filled[s] = 1'b0;
      end
    endfunction

    function void write_reg(logic [CFG_W-1:0] idx, logic [DIST_W-1:0] data);
      case (idx)
        REG_READY_MASK: ready_mask = data[MASK_W-1:0];
        REG_MIN_DIST:   min_dist = data;
        REG_MAX_DIST:   max_dist = data;
        default: ;
      endcase
    endfunction

    // Element count/2 of the sorted samples held so far.
    function logic [DIST_W-1:0] window_median(int s, int unsigned cnt);
      logic [DIST_W-1:0] sorted [WIN];
      logic [DIST_W-1:0] v;
      int j;
      for (int i = 0; i < cnt; i++) begin
        v = samples[s][i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      return sorted[cnt/2];
    endfunction

    function void note_request(logic [SEL_W-1:0] sel, logic [RAW_W-1:0] raw, logic tmo);
      dist_result_t r;
      logic [DIST_W-1:0] med;
      int unsigned cnt;
      int s;
      s = sel;
      r.sensor = sel;
      r.distance = '0;
      if (s < NSENS && s < MASK_W && ready_mask[s] && !tmo && raw < REJECT_LIMIT) begin
        samples[s][wr_pos[s]] = raw[DIST_W-1:0];
        wr_pos[s]++;
        if (wr_pos[s] == WIN) begin
          wr_pos[s] = 0;
          filled[s] = 1'b1;
        end
        cnt = filled[s] ? WIN : wr_pos[s];
        med = window_median(s, cnt);
        if (med >= min_dist && med <= max_dist) r.distance = med;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [SEL_W-1:0] sensor, logic [DIST_W-1:0] distance);
      dist_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: sensor_out %0d distance_mm %0d",
                 $time, sensor, distance);
        return;
      end
      e = expected_q.pop_front();
      if (sensor !== e.sensor) begin
        errors++;
        $display("%0t: sensor_out expected %0d actual %0d", $time, e.sensor, sensor);
      end
      if (distance !== e.distance) begin
        errors++;
        $display("%0t: distance_mm expected %0d actual %0d", $time, e.distance, distance);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic [SEL_W-1:0]    sensor_sel = '0;
  logic [RAW_W-1:0]    raw_mm = '0;
  logic                timed_out = 1'b0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic [SEL_W-1:0]    sensor_out;
  logic [DIST_W-1:0]   distance_mm;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_index = '0;
  logic [DIST_W-1:0]   cfg_data = '0;

  median_gate_sb sb;
  bit quiet = 1'b0;
  int hold_cycles = 0;
  int idle_cycles = 0;

  tof_median_range_gate u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .sensor_sel  (sensor_sel),
    .raw_mm      (raw_mm),
    .timed_out   (timed_out),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .sensor_out  (sensor_out),
    .distance_mm (distance_mm),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: stall for a random gap, a set hold or not at all, then take one result.
  initial begin : res_side
    int n;
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (res_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall === 1'b0)
      sb.check_result(sensor_out, distance_mm);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_stall === 1'b0) || (res_valid === 1'b1 && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input logic [SEL_W-1:0] sel, input logic [RAW_W-1:0] raw,
                          input logic tmo);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    sensor_sel <= sel;
    raw_mm <= raw;
    timed_out <= tmo;
    do @(posedge clk); while (req_stall !== 1'b0);
    sb.note_request(sel, raw, tmo);
  endtask

  // Hold off until every result is back, then let the pipeline settle.
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (WIN + 4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_W-1:0] idx, input logic [DIST_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [MASK_W-1:0] mask, input logic [DIST_W-1:0] lo,
                            input logic [DIST_W-1:0] hi);
    logic [DIST_W-1:0] mask_word;
    // Upper bits of the mask write are junk and must be dropped.
    mask_word = DIST_W'($urandom);
    mask_word[MASK_W-1:0] = mask;
    write_cfg(REG_READY_MASK, mask_word);
    write_cfg(REG_MIN_DIST, lo);
    write_cfg(REG_MAX_DIST, hi);
    write_cfg(REG_SPARE, DIST_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [MASK_W-1:0] m;
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    case ($urandom_range(0, 7))
      0: begin lo = '0; hi = '1; end
      1, 2: begin
        lo = DIST_W'($urandom_range(0, 4000));
        hi = DIST_W'($urandom_range(4000, 8191));
      end
      3: begin lo = DIST_W'($urandom); hi = DIST_W'($urandom); end
      4: begin lo = '1; hi = '0; end
      default: begin lo = MIN_DIST_RST; hi = MAX_DIST_RST; end
    endcase
    m = ($urandom_range(0, 3) == 0) ? MASK_W'($urandom) : READY_MASK_RST;
    set_config(m, lo, hi);
  endtask

  // Mostly good readings that feed the windows; the rest is rejected noise.
  task automatic send_random();
    int kind;
    kind = $urandom_range(0, 19);
    if (kind < 15)
      send_req(SEL_W'($urandom), RAW_W'($urandom_range(0, 8189)), 1'b0);
    else if (kind < 17)
      send_req(SEL_W'($urandom), RAW_W'($urandom_range(8180, 8189)), 1'b0);
    else if (kind == 17)
      send_req(SEL_W'($urandom), RAW_W'($urandom), 1'b1);
    else
      send_req(SEL_W'($urandom), RAW_W'($urandom_range(8190, 65535)), 1'($urandom));
  endtask

  initial begin : stimulus
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: extremes, rejects and a window wrap on sensor 0.
    send_req(1'b0, 16'd0, 1'b0);
    send_req(1'b0, 16'd8189, 1'b0);
    send_req(1'b0, 16'd8190, 1'b0);
    send_req(1'b0, 16'hFFFF, 1'b0);
    send_req(1'b0, 16'd100, 1'b1);
    send_req(1'b0, 16'd5000, 1'b0);
    send_req(1'b0, 16'd1, 1'b0);
    send_req(1'b0, 16'd8000, 1'b0);
    send_req(1'b0, 16'd3, 1'b0);
    send_req(1'b1, 16'd7, 1'b0);
    send_req(1'b1, 16'd8191, 1'b1);
    send_req(1'b1, 16'd42, 1'b0);
    send_req(1'b1, 16'hFFFF, 1'b1);

    // Sensor 1 not ready, narrow gate.
    drain();
    set_config(2'b01, 13'd10, 13'd6000);
    send_req(1'b1, 16'd500, 1'b0);
    send_req(1'b0, 16'd2, 1'b0);
    send_req(1'b0, 16'd7000, 1'b0);

    // Nothing ready, minimum above maximum.
    drain();
    set_config(2'b00, 13'd8191, 13'd0);
    send_req(1'b0, 16'd100, 1'b0);
    send_req(1'b1, 16'd100, 1'b0);

    // Gate of a single value.
    drain();
    set_config(2'b10, 13'd42, 13'd42);
    send_req(1'b1, 16'd42, 1'b0);
    send_req(1'b1, 16'd42, 1'b0);

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      random_config();
      quiet = (ph % 4 == 2);
      if (ph == 5) begin
        // Fill the block behind a long result stall.
        hold_cycles = LONG_HOLD;
        quiet = 1'b1;
        repeat (25) send_random();
        quiet = 1'b0;
      end
      repeat (73) send_random();
    end
    quiet = 1'b0;
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: tof_median_range_gate.f
+incdir+src
src/tmrg_pkg.sv
src/tmrg_cell.sv
src/tof_median_range_gate.sv
tb/sv/tb.sv
